// ===== rtl/swft_pkg.sv =====
package swft_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;
    localparam int TRY_W    = 4;
    localparam int CFG_IDX_W = 2;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // input opcodes
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESP    = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_BYTE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_ACKED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNEXPECT = 3'd3;
    localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd4;
    localparam logic [STAT_W-1:0] ST_GAVE_UP  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 2'd1;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] ADDRESS_RST   = 8'h03;
    localparam logic [TRY_W-1:0]  MAX_TRIES_RST = 4'd3;

    // link bytes
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h5D;
    localparam logic [BYTE_W-1:0] CTRL_SEQ0 = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_SEQ1 = 8'h80;
    localparam logic [BYTE_W-1:0] REJ_SEQ0  = 8'h54;
    localparam logic [BYTE_W-1:0] REJ_SEQ1  = 8'h55;
    localparam logic [BYTE_W-1:0] RR_SEQ0   = 8'h AA;
    localparam logic [BYTE_W-1:0] RR_SEQ1   = 8'hAB;

    // one classified item, handed from front to back
    typedef struct packed {
        logic              is_stat;
        logic              hdr;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [BYTE_W-1:0] bcc2;
        logic [STAT_W-1:0] status;
        logic              seq;
    } t_job;

    // queue occupancy flags
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // serialiser activity
    typedef struct packed {
        logic busy;
    } t_back_stat;

    // byte needs an escape prefix
    function automatic logic needs_esc(input logic [BYTE_W-1:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    // byte sent after the escape prefix
    function automatic logic [BYTE_W-1:0] esc_second(input logic [BYTE_W-1:0] b);
        return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

endpackage

// ===== rtl/swft_front.sv =====
module swft_front
    import swft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [BYTE_W-1:0]    i_byte_in,
    input  logic                 i_last_byte,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output t_job                 o_job
);

    logic              r_seq;
    logic [BYTE_W-1:0] r_xor;
    logic              r_inside;
    logic [TRY_W-1:0]  r_try;
    logic [BYTE_W-1:0] r_addr;
    logic [TRY_W-1:0]  r_max;

    logic              n_seq;
    logic [BYTE_W-1:0] n_xor;
    logic              n_inside;
    logic [TRY_W-1:0]  n_try;

    logic              accept;
    logic [BYTE_W-1:0] xor_acc;
    logic [TRY_W-1:0]  try_next;
    logic              give_up;
    logic [BYTE_W-1:0] rr_code;
    logic [BYTE_W-1:0] rej_code;

    assign o_in_stall  = i_q_stat.full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_stat.full;

    // classify the item and work out the state it leaves
    always_comb begin
        xor_acc  = (r_inside ? r_xor : '0) ^ i_byte_in;
        try_next = r_try + 1'b1;
        give_up  = (try_next >= r_max) || (try_next == '0);
        rr_code  = r_seq ? RR_SEQ1 : RR_SEQ0;
        rej_code = r_seq ? REJ_SEQ1 : REJ_SEQ0;

        n_seq    = r_seq;
        n_xor    = r_xor;
        n_inside = r_inside;
        n_try    = r_try;
        o_push   = 1'b0;

        o_job         = '0;
        o_job.addr    = r_addr;
        o_job.data    = i_byte_in;
        o_job.last    = i_last_byte;
        o_job.bcc2    = xor_acc;
        o_job.seq     = r_seq;
        o_job.hdr     = !r_inside;
        o_job.status  = ST_BYTE;

        if (accept) begin
            unique case (i_opcode)
                OP_BYTE: begin
                    o_push   = 1'b1;
                    n_xor    = i_last_byte ? '0 : xor_acc;
                    n_inside = !i_last_byte;
                end
                OP_RESP: begin
                    o_push        = 1'b1;
                    o_job.is_stat = 1'b1;
                    priority if (i_byte_in == rr_code) begin
                        n_seq        = !r_seq;
                        n_try        = '0;
                        o_job.status = ST_ACKED;
                    end else if (give_up) begin
                        n_try        = '0;
                        o_job.status = ST_GAVE_UP;
                    end else begin
                        n_try        = try_next;
                        o_job.status = (i_byte_in == rej_code) ? ST_REJECTED : ST_UNEXPECT;
                    end
                    o_job.seq = n_seq;
                end
                OP_TIMEOUT: begin
                    o_push        = 1'b1;
                    o_job.is_stat = 1'b1;
                    n_try         = give_up ? '0 : try_next;
                    o_job.status  = give_up ? ST_GAVE_UP : ST_TIMEOUT;
                end
                default: begin
                    // unused opcode: taken and dropped
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= 1'b0;
            r_xor    <= '0;
            r_inside <= 1'b0;
            r_try    <= '0;
        end else begin
            r_seq    <= n_seq;
            r_xor    <= n_xor;
            r_inside <= n_inside;
            r_try    <= n_try;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= ADDRESS_RST;
            r_max  <= MAX_TRIES_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ADDRESS) begin
                r_addr <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAX_TRIES) begin
                r_max <= i_cfg_data[TRY_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/swft_queue.sv =====
module swft_queue
    import swft_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_FULL);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/swft_back.sv =====
module swft_back
    import swft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output t_back_stat        o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [STAT_W-1:0] o_status,
    output logic              o_end_of_run,
    output logic              o_seq_now
);

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_FLAG0 = 4'd0;
    localparam logic [PH_W-1:0] PH_ADDR  = 4'd1;
    localparam logic [PH_W-1:0] PH_CTRL  = 4'd2;
    localparam logic [PH_W-1:0] PH_BCC1  = 4'd3;
    localparam logic [PH_W-1:0] PH_D0    = 4'd4;
    localparam logic [PH_W-1:0] PH_D1    = 4'd5;
    localparam logic [PH_W-1:0] PH_B0    = 4'd6;
    localparam logic [PH_W-1:0] PH_B1    = 4'd7;
    localparam logic [PH_W-1:0] PH_FLAG1 = 4'd8;
    localparam logic [PH_W-1:0] PH_STAT  = 4'd9;

    logic              r_busy;
    t_job              r_job;
    logic [PH_W-1:0]   r_phase;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [STAT_W-1:0] r_status;
    logic              r_end;
    logic              r_seq_now;

    logic              n_busy;
    logic [PH_W-1:0]   n_phase;

    logic              out_free;
    logic              emit;
    logic              fin;
    logic [PH_W-1:0]   ph_next;
    logic [PH_W-1:0]   ph_start;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] cur_byte;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = r_busy && out_free;
    assign o_stat.busy = r_busy;
    assign ctrl        = r_job.seq ? CTRL_SEQ1 : CTRL_SEQ0;

    // byte of the current phase and the phase that follows
    always_comb begin
        cur_byte = '0;
        ph_next  = PH_STAT;
        fin      = 1'b0;
        unique case (r_phase)
            PH_FLAG0: begin
                cur_byte = FLAG_BYTE;
                ph_next  = PH_ADDR;
            end
            PH_ADDR: begin
                cur_byte = r_job.addr;
                ph_next  = PH_CTRL;
            end
            PH_CTRL: begin
                cur_byte = ctrl;
                ph_next  = PH_BCC1;
            end
            PH_BCC1: begin
                cur_byte = r_job.addr ^ ctrl;
                ph_next  = PH_D0;
            end
            PH_D0: begin
                cur_byte = needs_esc(r_job.data) ? ESC_BYTE : r_job.data;
                ph_next  = needs_esc(r_job.data) ? PH_D1 : PH_B0;
                fin      = !needs_esc(r_job.data) && !r_job.last;
            end
            PH_D1: begin
                cur_byte = esc_second(r_job.data);
                ph_next  = PH_B0;
                fin      = !r_job.last;
            end
            PH_B0: begin
                cur_byte = needs_esc(r_job.bcc2) ? ESC_BYTE : r_job.bcc2;
                ph_next  = needs_esc(r_job.bcc2) ? PH_B1 : PH_FLAG1;
            end
            PH_B1: begin
                cur_byte = esc_second(r_job.bcc2);
                ph_next  = PH_FLAG1;
            end
            PH_FLAG1: begin
                cur_byte = FLAG_BYTE;
                fin      = 1'b1;
            end
            PH_STAT: begin
                cur_byte = '0;
                fin      = 1'b1;
            end
            default: begin
                cur_byte = '0;
                fin      = 1'b1;
            end
        endcase
    end

    // first phase of the job at the queue head
    always_comb begin
        if (i_job.is_stat) begin
            ph_start = PH_STAT;
        end else if (i_job.hdr) begin
            ph_start = PH_FLAG0;
        end else begin
            ph_start = PH_D0;
        end
    end

    // load the next job when idle or as the current one finishes
    always_comb begin
        o_pop   = !i_q_stat.empty && (!r_busy || (emit && fin));
        n_busy  = r_busy;
        n_phase = r_phase;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_phase = ph_start;
        end else if (emit) begin
            n_busy  = !fin;
            n_phase = ph_next;
        end
    end

    // serialiser control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_STAT;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_status   <= r_job.is_stat ? r_job.status : ST_BYTE;
            r_end      <= fin;
            r_seq_now  <= r_job.seq;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_status     = r_status;
    assign o_end_of_run = r_end;
    assign o_seq_now    = r_seq_now;

endmodule

// ===== rtl/stop_and_wait_frame_transmitter_unit.sv =====
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_byte_in, i_last_byte
// result    out        o_out_valid / i_out_stall o_out_byte, o_status, o_end_of_run, o_seq_now
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// results leave one per cycle from the output serialiser, which sets the rate, unless i_out_stall holds it
// a payload byte gives 1 output byte, 2 when stuffed; a frame start adds 4, a
// frame end adds 2 or 3; a response or timeout gives 1 result
// synchronous active-low reset clears link state, queue and output, config to 3 / 3
// a job queue of QUEUE_DEPTH entries and the output register decouple the two stalls
module stop_and_wait_frame_transmitter_unit
    import swft_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [BYTE_W-1:0]    i_byte_in,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic [STAT_W-1:0]    o_status,
    output logic                 o_end_of_run,
    output logic                 o_seq_now,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic       push;
    logic       pop;
    t_job       job_in;
    t_job       job_head;
    t_q_stat    q_stat;
    t_back_stat back_stat;

    // classify items and keep link state
    swft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (job_in)
    );

    // job queue
    swft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_head),
        .o_stat  (q_stat)
    );

    // byte serialiser and output register
    swft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job_head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_stat       (back_stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_end_of_run (o_end_of_run),
        .o_seq_now    (o_seq_now)
    );

`ifndef NO_ASSERTIONS
    // a status result is always the only one of its transfer run and carries no byte
    a_stat_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_BYTE)) |-> (o_end_of_run && (o_out_byte == '0)))
        else $error("status result without end of run or with nonzero byte");

    // no result appears out of an idle back end and an empty queue
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!back_stat.busy && q_stat.empty && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared with no queued work");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");
`endif

endmodule
